@@ hw/rtl/dtus_pkg.sv @@
// Shared types and constants of the distance tier classifier.
// Used by the channel interfaces, the controller, the datapath and the top level.
package dtus_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int POS_WIDTH   = 16;
	localparam int MAX_PERIOD  = 60;

	localparam int RADIUS_W  = 16;
	localparam int PERIOD_W  = 6;
	localparam int SCALE_W   = 6;
	localparam int TOTAL_W   = 16;
	localparam int FRAME_W   = 32;
	localparam int ADDR_W    = 32;
	localparam int TIER_W    = 2;
	localparam int KEY_W     = 8;
	localparam int KEY_LSB   = ADDR_W - KEY_W;
	localparam int HASH_SHIFT = 4;

	localparam int EFF_PER_W = $clog2(MAX_PERIOD + 1);
	localparam int PER_CMP_W = (PERIOD_W > EFF_PER_W) ? PERIOD_W : EFF_PER_W;

	localparam int SQ_W   = (POS_WIDTH > RADIUS_W) ? POS_WIDTH : RADIUS_W;
	localparam int PROD_W = 2 * SQ_W;
	localparam int DIST_W = PROD_W + 1;

	localparam int MOD_DIGIT = 4;
	localparam int MOD_STEPS = FRAME_W / MOD_DIGIT;
	localparam int STEP_W    = $clog2(MOD_STEPS);

	localparam int NUM_REGS   = 5;
	localparam int CFG_IDX_W  = $clog2(NUM_REGS);
	localparam int CFG_DATA_W = 16;

	localparam logic [ADDR_W-1:0]  HASH_MUL   = 32'd2654435761;
	localparam logic [FRAME_W-1:0] FRAME_NONE = 32'hFFFF_FFFF;

	localparam logic [CFG_IDX_W-1:0] REG_NEAR_RADIUS    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MID_RADIUS     = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_STAGGER_PERIOD = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_STRETCH_TICK   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_CULL_FAR_DRAW  = CFG_IDX_W'(4);

	localparam logic [TIER_W-1:0] TIER_NEAR = TIER_W'(0);
	localparam logic [TIER_W-1:0] TIER_MID  = TIER_W'(1);
	localparam logic [TIER_W-1:0] TIER_FAR  = TIER_W'(2);

	localparam logic [STEP_W-1:0] SQ_AX    = STEP_W'(0);
	localparam logic [STEP_W-1:0] SQ_AZ    = STEP_W'(1);
	localparam logic [STEP_W-1:0] SQ_NEAR  = STEP_W'(2);
	localparam logic [STEP_W-1:0] SQ_MID   = STEP_W'(3);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MOD_STEPS - 1);

	typedef struct packed {
		logic                        command;
		logic [FRAME_W-1:0]          frame_number;
		logic [ADDR_W-1:0]           object_address;
		logic                        exempt;
		logic signed [POS_WIDTH-1:0] object_x;
		logic signed [POS_WIDTH-1:0] object_z;
		logic signed [POS_WIDTH-1:0] viewer_x;
		logic signed [POS_WIDTH-1:0] viewer_z;
	} in_item_t;

	typedef struct packed {
		logic               skip_update;
		logic               skip_draw;
		logic [TIER_W-1:0]  tier;
		logic [SCALE_W-1:0] tick_scale;
		logic [TOTAL_W-1:0] near_total;
		logic [TOTAL_W-1:0] mid_total;
		logic [TOTAL_W-1:0] far_total;
	} out_item_t;

	typedef struct packed {
		logic              load;
		logic              prep;
		logic              work;
		logic [STEP_W-1:0] step;
		logic              finish;
	} dtus_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic out_stall;
	} dtus_sts_t;

endpackage

@@ hw/rtl/dtus_in_if.sv @@
// Input channel: valid/ready handshake carrying one classify or clear item.
// Depends on dtus_pkg for the item type.
interface dtus_in_if;
	import dtus_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/dtus_out_if.sv @@
// Result channel: valid/ready handshake carrying one result item.
// Depends on dtus_pkg for the item type.
interface dtus_out_if;
	import dtus_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/dtus_ctrl.sv @@
// Sequencer of the tier classifier: accept, prepare, eight work steps (none for a clear), finish.
// Depends on dtus_pkg; drives the datapath by command and reads its status.
module dtus_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dtus_pkg::dtus_sts_t sts,
	output dtus_pkg::dtus_cmd_t cmd
);
	import dtus_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_WORK = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	always_comb begin
		state_d    = state_q;
		step_d     = step_q;
		in_ready   = 1'b0;
		cmd        = '0;
		cmd.step   = step_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				step_d   = '0;
				state_d  = sts.is_clear ? ST_DONE : ST_WORK;
			end
			ST_WORK: begin
				cmd.work = 1'b1;
				step_d   = step_q + 1'b1;
				if (step_q == STEP_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!sts.out_stall) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_load_to_prep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_PREP)
		else $error("accepted item did not enter preparation");

	a_last_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WORK && step_q == STEP_LAST) |=> state_q == ST_DONE)
		else $error("work steps did not end after the last digit");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && sts.out_stall) |=> state_q == ST_DONE)
		else $error("finish left while result register was full");
`endif
endmodule

@@ hw/rtl/dtus_dp.sv @@
// Datapath of the tier classifier: configuration, shared squarer, digit-serial
// stagger modulo, frame counters and the result register. Depends on dtus_pkg.
module dtus_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dtus_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dtus_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  dtus_pkg::in_item_t                  in_data,
	input  dtus_pkg::dtus_cmd_t                 cmd,
	output dtus_pkg::dtus_sts_t                 sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output dtus_pkg::out_item_t                 out_data
);
	import dtus_pkg::*;

	function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
		return (&c) ? c : COUNT_WIDTH'(c + 1'b1);
	endfunction

	logic [RADIUS_W-1:0]    near_radius_q, mid_radius_q;
	logic [PERIOD_W-1:0]    stagger_q;
	logic                   stretch_q, cull_q;

	in_item_t               item_q;
	logic [POS_WIDTH-1:0]   ax_q, az_q;
	logic [FRAME_W-1:0]     phase_q;
	logic [EFF_PER_W-1:0]   rem_q;
	logic [PROD_W-1:0]      sqx_q, sqz_q, nsq_q, msq_q;

	logic [COUNT_WIDTH-1:0] acc_near_q, acc_mid_q, acc_far_q;
	logic [COUNT_WIDTH-1:0] pub_near_q, pub_mid_q, pub_far_q;
	logic [FRAME_W-1:0]     cur_frame_q;
	logic [EFF_PER_W-1:0]   scale_q;

	logic                   out_valid_q;
	out_item_t              out_data_q;

	logic [EFF_PER_W-1:0]   per_eff;
	logic [PER_CMP_W-1:0]   per_cmp;
	logic [POS_WIDTH:0]     dx, dz;
	logic [POS_WIDTH-1:0]   ax, az;
	logic [ADDR_W-1:0]      hash_prod;
	logic [SQ_W-1:0]        mul_op;
	logic [PROD_W-1:0]      prod;
	logic [EFF_PER_W-1:0]   rem_next;
	logic [FRAME_W-1:0]     phase_next;

	logic [DIST_W-1:0]      dist_sq;
	logic                   is_near, is_far, mid_go, frame_new;
	logic [COUNT_WIDTH-1:0] an_d, am_d, af_d, pn_d, pm_d, pf_d;
	logic [EFF_PER_W-1:0]   scale_d;
	out_item_t              res;

	// effective period
	always_comb begin
		per_cmp = PER_CMP_W'(stagger_q);
		if (stagger_q == '0) begin
			per_eff = EFF_PER_W'(1);
		end else if (per_cmp > PER_CMP_W'(MAX_PERIOD)) begin
			per_eff = EFF_PER_W'(MAX_PERIOD);
		end else begin
			per_eff = EFF_PER_W'(stagger_q);
		end
	end

	// preparation: distances and stagger phase
	always_comb begin
		dx = {item_q.object_x[POS_WIDTH-1], item_q.object_x}
			- {item_q.viewer_x[POS_WIDTH-1], item_q.viewer_x};
		dz = {item_q.object_z[POS_WIDTH-1], item_q.object_z}
			- {item_q.viewer_z[POS_WIDTH-1], item_q.viewer_z};
		ax = dx[POS_WIDTH] ? POS_WIDTH'(-dx) : POS_WIDTH'(dx);
		az = dz[POS_WIDTH] ? POS_WIDTH'(-dz) : POS_WIDTH'(dz);
		hash_prod = ADDR_W'((item_q.object_address >> HASH_SHIFT) * HASH_MUL);
	end

	// shared squarer
	always_comb begin
		case (cmd.step)
			SQ_AX:   mul_op = SQ_W'(ax_q);
			SQ_AZ:   mul_op = SQ_W'(az_q);
			SQ_NEAR: mul_op = SQ_W'(near_radius_q);
			SQ_MID:  mul_op = SQ_W'(mid_radius_q);
			default: mul_op = '0;
		endcase
		prod = PROD_W'(mul_op * mul_op);
	end

	// restoring remainder, one digit per step
	always_comb begin
		logic [EFF_PER_W:0]   trial;
		logic [EFF_PER_W-1:0] r;
		logic [FRAME_W-1:0]   p;
		r = rem_q;
		p = phase_q;
		for (int i = 0; i < MOD_DIGIT; i++) begin
			trial = {r, p[FRAME_W-1]};
			p = p << 1;
			if (trial >= {1'b0, per_eff}) begin
				trial = trial - {1'b0, per_eff};
			end
			r = trial[EFF_PER_W-1:0];
		end
		rem_next   = r;
		phase_next = p;
	end

	// classification and statistics
	always_comb begin
		dist_sq   = DIST_W'(sqx_q) + DIST_W'(sqz_q);
		is_near   = item_q.exempt || (dist_sq <= DIST_W'(nsq_q));
		is_far    = dist_sq > DIST_W'(msq_q);
		mid_go    = rem_q == '0;
		frame_new = item_q.frame_number != cur_frame_q;

		pn_d = frame_new ? acc_near_q : pub_near_q;
		pm_d = frame_new ? acc_mid_q : pub_mid_q;
		pf_d = frame_new ? acc_far_q : pub_far_q;
		an_d = frame_new ? '0 : acc_near_q;
		am_d = frame_new ? '0 : acc_mid_q;
		af_d = frame_new ? '0 : acc_far_q;
		scale_d = scale_q;
		res = '0;

		if (is_near) begin
			an_d    = bump(an_d);
			scale_d = EFF_PER_W'(1);
			res.tier = TIER_NEAR;
		end else if (is_far) begin
			af_d = bump(af_d);
			res.tier        = TIER_FAR;
			res.skip_update = 1'b1;
			res.skip_draw   = cull_q;
		end else begin
			am_d = bump(am_d);
			res.tier = TIER_MID;
			if (mid_go) begin
				scale_d = stretch_q ? per_eff : EFF_PER_W'(1);
			end else begin
				res.skip_update = 1'b1;
			end
		end

		if (item_q.command) begin
			an_d = '0;
			am_d = '0;
			af_d = '0;
			pn_d = '0;
			pm_d = '0;
			pf_d = '0;
			scale_d = EFF_PER_W'(1);
			res = '0;
		end
		res.tick_scale = SCALE_W'(scale_d);
		res.near_total = TOTAL_W'(pn_d);
		res.mid_total  = TOTAL_W'(pm_d);
		res.far_total  = TOTAL_W'(pf_d);
	end

	// configuration and frame statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_radius_q <= '0;
			mid_radius_q  <= '0;
			stagger_q     <= PERIOD_W'(1);
			stretch_q     <= 1'b0;
			cull_q        <= 1'b0;
			acc_near_q    <= '0;
			acc_mid_q     <= '0;
			acc_far_q     <= '0;
			pub_near_q    <= '0;
			pub_mid_q     <= '0;
			pub_far_q     <= '0;
			cur_frame_q   <= FRAME_NONE;
			scale_q       <= EFF_PER_W'(1);
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_NEAR_RADIUS:    near_radius_q <= cfg_wdata[RADIUS_W-1:0];
					REG_MID_RADIUS:     mid_radius_q  <= cfg_wdata[RADIUS_W-1:0];
					REG_STAGGER_PERIOD: stagger_q     <= cfg_wdata[PERIOD_W-1:0];
					REG_STRETCH_TICK:   stretch_q     <= cfg_wdata[0];
					REG_CULL_FAR_DRAW:  cull_q        <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (cmd.finish) begin
				acc_near_q  <= an_d;
				acc_mid_q   <= am_d;
				acc_far_q   <= af_d;
				pub_near_q  <= pn_d;
				pub_mid_q   <= pm_d;
				pub_far_q   <= pf_d;
				scale_q     <= scale_d;
				cur_frame_q <= item_q.command ? FRAME_NONE : item_q.frame_number;
				if (item_q.command) begin
					stretch_q <= 1'b0;
					cull_q    <= 1'b0;
				end
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item payload and work registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (cmd.prep) begin
			ax_q    <= ax;
			az_q    <= az;
			phase_q <= item_q.frame_number + FRAME_W'(hash_prod[ADDR_W-1:KEY_LSB]);
			rem_q   <= '0;
		end
		if (cmd.work) begin
			phase_q <= phase_next;
			rem_q   <= rem_next;
			case (cmd.step)
				SQ_AX:   sqx_q <= prod;
				SQ_AZ:   sqz_q <= prod;
				SQ_NEAR: nsq_q <= prod;
				SQ_MID:  msq_q <= prod;
				default: ;
			endcase
		end
		if (cmd.finish) begin
			out_data_q <= res;
		end
	end

	assign sts.is_clear  = item_q.command;
	assign sts.out_stall = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_data_q;

`ifndef NO_ASSERTIONS
	a_valid_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.finish))
		else $error("result appeared without a finish step");

	a_scale_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_data_q.tick_scale != '0)
		else $error("tick scale of zero on the result");

	a_far_skips: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.tier == TIER_FAR) |-> out_data_q.skip_update)
		else $error("far object allowed to update");
`endif
endmodule

@@ hw/rtl/distance_tier_update_stagger.sv @@
// Top level of the distance tier classifier with staggered updates.
// Depends on dtus_pkg, dtus_in_if, dtus_out_if, dtus_ctrl and dtus_dp.
//
//   port       kind         carries
//   req        valid/ready  command, frame, address, exempt flag, XZ positions
//   rsp        valid/ready  skip flags, tier, tick scale, published totals
//   cfg_*      write only   radii, stagger period, tick stretch, far draw cull
//
// A classify item blocks the input from acceptance on: one step to prepare distances
// and the stagger phase, eight steps of the shared squarer and the 4-bit-per-step
// remainder unit, one to classify. A clear skips the eight steps. The result
// register lets the next item in while a result waits; the finish step holds while
// it is full and unread. Reset sets control, config and totals, not item data.
module distance_tier_update_stagger (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dtus_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dtus_pkg::CFG_DATA_W-1:0] cfg_wdata,
	dtus_in_if.sink                         req,
	dtus_out_if.source                      rsp
);
	import dtus_pkg::*;

	dtus_cmd_t cmd;
	dtus_sts_t sts;
	logic      in_ready;
	logic      out_valid;
	out_item_t out_data;

	dtus_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dtus_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (req.data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.out_data  (out_data)
	);

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;
	assign rsp.data  = out_data;
endmodule
